[src/gdst_pkg.sv]
// ----------------------------------------------------------------------------
// gdst_pkg: shared types and constants of the distance send trigger
// Field widths, mode and register codes, and the fixed-point constants of
// the CORDIC datapath, which are built at elaboration time.
// ----------------------------------------------------------------------------
package gdst_pkg;

  // Number of CORDIC micro-rotations per pass.
  localparam int CORDIC_STEPS = 32;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);

  // Beat fields.
  localparam int MODE_W     = 2;
  localparam int LAT_W      = 31;
  localparam int LON_W      = 32;
  localparam int STEP_W     = 29;
  localparam int SUM_W      = 32;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Datapath widths.
  localparam int ANG_W  = 64;  // Q60 radians
  localparam int XY_W   = 40;  // CORDIC x and y
  localparam int OPD_W  = 35;  // multiplier operands
  localparam int PROD_W = 70;  // multiplier product
  localparam int RED_W  = 34;  // angle in 1e-7 degree during reduction
  localparam int SQRT_IN_W = 64;
  localparam int SQRT_W    = 32;
  localparam int REM_W     = 36;
  localparam int SQRT_CNT_W = $clog2(SQRT_W);

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_POS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOME  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT = 2'd1;

  localparam logic [TICK_W-1:0] TIME_LIMIT_RESET = 16'd3000;
  localparam logic [SUM_W-1:0]  DIST_LIMIT_RESET = 32'd480;

  localparam longint DEG_FULL = 64'd3600000000;
  localparam longint DEG_HALF = 64'd1800000000;
  localparam logic [63:0] EARTH_K  = 64'd101964720;  // radius in 1/16 m
  localparam logic [31:0] STEP_MAX = 32'd320400000;

  typedef logic signed [ANG_W-1:0] angle_t;
  typedef angle_t [CORDIC_STEPS-1:0] atan_tab_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_cmd_t;

  // Unsigned quotient by restoring long division, for elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = 64'd0;
    r = 65'd0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[63:0], num[j]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of the reciprocal of n in Q60 by its alternating series.
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] t;
    logic [63:0] n2;
    logic [63:0] s;
    logic [63:0] k;
    logic        sub;
    logic        run;
    t   = udiv64(64'd1 << 60, n);
    n2  = n * n;
    s   = t;
    k   = 64'd1;
    sub = 1'b1;
    run = 1'b1;
    for (int j = 0; j < 64; j++) begin
      if (run) begin
        t = udiv64(t, n2);
        if (t == 64'd0) begin
          run = 1'b0;
        end else begin
          if (sub) s = s - udiv64(t, 64'd2 * k + 64'd1);
          else     s = s + udiv64(t, 64'd2 * k + 64'd1);
          sub = !sub;
          k   = k + 64'd1;
        end
      end
    end
    return s;
  endfunction

  // Floor square root, bit-pair method.
  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    x = v;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > x) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  localparam logic [63:0] PI_Q  = 64'd4 * (64'd4 * atan_recip(64'd5) - atan_recip(64'd239));
  localparam logic [63:0] DEG_K = PI_Q / 64'd1800000000;
  localparam angle_t PI_A   = angle_t'(PI_Q);
  localparam angle_t HALF_A = angle_t'(PI_Q / 64'd2);

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t   tab;
    logic [63:0] s;
    logic [63:0] term;
    int          e;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        tab[i] = angle_t'(PI_Q >> 2);
      end else begin
        s = 64'd0;
        for (int k = 0; k < 32; k++) begin
          e = i * (2 * k + 1);
          if (e <= 60) begin
            term = udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
            s = k[0] ? s - term : s + term;
          end
        end
        tab[i] = angle_t'(s);
      end
    end
    return tab;
  endfunction

  function automatic logic [63:0] build_inv_gain();
    logic [63:0] p;
    logic [63:0] q;
    p = 64'd1 << 30;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      p = p + (p >> (2 * i));
    end
    q = udiv64(64'd1 << 62, p);
    return isqrt_c(q << 28);
  endfunction

  localparam atan_tab_t   ATAN_TAB = build_atan_tab();
  localparam logic [63:0] INV_GAIN = build_inv_gain();

endpackage

[src/gdst_item_if.sv]
// ----------------------------------------------------------------------------
// gdst_item_if: input item channel
// Carries the mode, latitude and longitude of one input beat.
// ----------------------------------------------------------------------------
interface gdst_item_if import gdst_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [LAT_W-1:0]  latitude;
  logic signed [LON_W-1:0]  longitude;

  modport source (output valid, mode, latitude, longitude, input ready);
  modport sink   (input valid, mode, latitude, longitude, output ready);
endinterface

[src/gdst_result_if.sv]
// ----------------------------------------------------------------------------
// gdst_result_if: result channel
// Carries the step distance, travelled total and send flag of one beat.
// ----------------------------------------------------------------------------
interface gdst_result_if import gdst_pkg::*;;
  logic               valid;
  logic               ready;
  logic [STEP_W-1:0]  step_distance;
  logic [SUM_W-1:0]   travelled_total;
  logic               send_due;

  modport source (output valid, step_distance, travelled_total, send_due, input ready);
  modport sink   (input valid, step_distance, travelled_total, send_due, output ready);
endinterface

[src/gdst_cfg_if.sv]
// ----------------------------------------------------------------------------
// gdst_cfg_if: configuration write channel
// Carries a register index and the data written to it.
// ----------------------------------------------------------------------------
interface gdst_cfg_if import gdst_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/gdst_cordic.sv]
// ----------------------------------------------------------------------------
// gdst_cordic: shared CORDIC unit
// Runs one rotation or vectoring pass of CORDIC_STEPS micro-rotations.
// ----------------------------------------------------------------------------
module gdst_cordic import gdst_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cordic_cmd_t             cmd,
  input  logic signed [XY_W-1:0]  x_init,
  input  logic signed [XY_W-1:0]  y_init,
  input  angle_t                  z_init,
  output logic                    done,
  output logic signed [XY_W-1:0]  x_out,
  output logic signed [XY_W-1:0]  y_out,
  output angle_t                  z_out
);

  logic signed [XY_W-1:0] x, y, xs, ys;
  angle_t                 z;
  logic                   vec;
  logic                   busy;
  logic [ITER_W-1:0]      iter;
  logic                   neg;

  // Rotation drives z toward zero, vectoring drives y toward zero.
  always_comb begin
    xs  = x >>> iter;
    ys  = y >>> iter;
    neg = vec ? (y > 0) : (z < 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x   <= x_init;
      y   <= y_init;
      z   <= z_init;
      vec <= cmd.vectoring;
    end else if (busy) begin
      if (neg) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ATAN_TAB[iter];
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ATAN_TAB[iter];
      end
    end
  end

  assign x_out = x;
  assign y_out = y;
  assign z_out = z;

endmodule

[src/gdst_isqrt.sv]
// ----------------------------------------------------------------------------
// gdst_isqrt: iterative integer square root
// Produces the floor root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module gdst_isqrt import gdst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SQRT_IN_W-1:0]  radicand,
  output logic                  done,
  output logic [SQRT_W-1:0]     root
);

  logic [SQRT_IN_W-1:0]  rad;
  logic [REM_W-1:0]      rem;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  busy;
  logic [SQRT_CNT_W-1:0] cnt;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[SQRT_IN_W-1 -: 2]};
    trial  = REM_W'({root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SQRT_CNT_W'(SQRT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[SQRT_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[SQRT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[SQRT_W-2:0], 1'b0};
      end
    end
  end

endmodule

[src/gdst_mul.sv]
// ----------------------------------------------------------------------------
// gdst_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module gdst_mul import gdst_pkg::*; (
  input  logic                      clk,
  input  logic signed [OPD_W-1:0]   a,
  input  logic signed [OPD_W-1:0]   b,
  output logic signed [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

[src/gps_distance_send_trigger_unit.sv]
// ----------------------------------------------------------------------------
// gps_distance_send_trigger_unit: beacon send trigger from GPS distance
// Accumulates great-circle travel between fixes and elapsed ticks, and flags
// when a new frame should be sent.
// ----------------------------------------------------------------------------
// Each input beat carries a mode. A position fix measures the great-circle
// distance on a sphere of radius 6372795 m from the stored position to the
// new one, adds it (saturating) to the travelled total in 1/16 m and stores
// the new position. A home fix only stores the position, a time tick advances
// the saturating elapsed counter, and a frame-sent beat clears counter and
// total. Every input beat yields exactly one result beat with send_due set
// when the elapsed count or the total has reached its configured limit.
// Home fixes, ticks and frame-sent beats load their result at the edge that
// accepts them. A position fix makes three rotation passes, for the sines and
// cosines of both latitudes and of the longitude difference, each made of a
// range check that wraps the angle into (-180, 180] degrees where needed, a
// scaling product and a pass of the shared CORDIC unit. Ten further products
// on the one shared multiplier follow, with the square root and the vectoring
// pass for the arctangent among them; a last state loads the result. While a
// fix is in work the block does not take input beats; configuration writes
// are always taken and must only be issued while the block is idle. After
// reset the elapsed counter is at its maximum, so send_due is set in every
// result beat until a frame-sent beat clears the counter.
// ----------------------------------------------------------------------------
module gps_distance_send_trigger_unit import gdst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  gdst_item_if.sink     item,
  gdst_result_if.source result,
  gdst_cfg_if.sink      cfg
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;  // periodic reduction of the angle
  localparam logic [3:0] S_MUL  = 4'd2;  // operands to the multiplier
  localparam logic [3:0] S_MULW = 4'd3;  // product back from the multiplier
  localparam logic [3:0] S_ROT  = 4'd4;  // rotation pass in progress
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_VGO  = 4'd6;
  localparam logic [3:0] S_VEC  = 4'd7;  // vectoring pass in progress
  localparam logic [3:0] S_DONE = 4'd8;

  // Multiplier operations, in issue order.
  localparam logic [3:0] OP_ANGLE = 4'd0;
  localparam logic [3:0] OP_C1S2  = 4'd1;
  localparam logic [3:0] OP_S1C2  = 4'd2;
  localparam logic [3:0] OP_T2CD  = 4'd3;
  localparam logic [3:0] OP_C2SD  = 4'd4;
  localparam logic [3:0] OP_S1S2  = 4'd5;
  localparam logic [3:0] OP_C1C2  = 4'd6;
  localparam logic [3:0] OP_T4CD  = 4'd7;
  localparam logic [3:0] OP_AA    = 4'd8;
  localparam logic [3:0] OP_BB    = 4'd9;
  localparam logic [3:0] OP_DIST  = 4'd10;

  // Which angle the rotation pass works on.
  localparam logic [1:0] SEL_LAT1 = 2'd0;
  localparam logic [1:0] SEL_LAT2 = 2'd1;
  localparam logic [1:0] SEL_DLON = 2'd2;

  localparam logic signed [RED_W-1:0] RED_HALF = RED_W'(DEG_HALF);
  localparam logic signed [RED_W-1:0] RED_FULL = RED_W'(DEG_FULL);

  logic [3:0] state;
  logic [3:0] op;
  logic [1:0] sel;

  // Configuration registers.
  logic [TICK_W-1:0] time_limit;
  logic [SUM_W-1:0]  dist_limit;

  // Architectural state.
  logic signed [LAT_W-1:0] prev_lat;
  logic signed [LON_W-1:0] prev_lon;
  logic [SUM_W-1:0]        distance_sum, distance_sum_next;
  logic [TICK_W-1:0]       elapsed, elapsed_next;

  // Working registers of one position fix.
  logic signed [LAT_W-1:0] lat_new;
  logic signed [LON_W-1:0] lon_new;
  logic signed [RED_W-1:0] m;
  logic                    flip;
  logic signed [OPD_W-1:0] c1, s1, c2, s2, cd, sd;
  logic signed [OPD_W-1:0] tmp, acc_a, acc_b, den, zq;
  logic [63:0]             sq;
  logic [SQRT_W-1:0]       num;
  logic [STEP_W-1:0]       step;

  // Result register.
  logic               out_valid;
  logic [STEP_W-1:0]  out_step;
  logic [SUM_W-1:0]   out_total;
  logic               out_due;

  logic in_fire, res_free, commit, out_write;

  // Shared units.
  logic signed [OPD_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [OPD_W-1:0]  prod_sh;
  logic [63:0]              sq_sum;

  cordic_cmd_t             ccmd;
  logic signed [XY_W-1:0]  cx_init, cy_init, cx, cy;
  angle_t                  cz_init, cz;
  logic                    cdone;

  logic                    sq_start, sq_done;
  logic [SQRT_W-1:0]       sq_root;

  // Angle handling at the end of the scaling multiply.
  angle_t                  zp, zf;
  logic                    zflip;
  logic signed [OPD_W-1:0] cval, sval;
  angle_t                  zabs;
  logic [63:0]             dround;
  logic [31:0]             dval;
  logic signed [RED_W-1:0] angle_src;
  logic [SUM_W:0]          sum_add;

  gdst_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  gdst_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ccmd),
    .x_init (cx_init),
    .y_init (cy_init),
    .z_init (cz_init),
    .done   (cdone),
    .x_out  (cx),
    .y_out  (cy),
    .z_out  (cz)
  );

  gdst_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_sum),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Handshakes. The result register frees itself in the cycle it is taken,
  // so a new beat can enter while the previous result is leaving.
  assign res_free     = !out_valid || result.ready;
  assign item.ready   = (state == S_IDLE) && res_free;
  assign in_fire      = item.valid && item.ready;
  assign cfg.ready    = 1'b1;
  assign commit       = (state == S_DONE) && res_free;
  assign out_write    = (in_fire && (item.mode != MODE_POS)) || commit;

  assign result.valid           = out_valid;
  assign result.step_distance   = out_step;
  assign result.travelled_total = out_total;
  assign result.send_due        = out_due;

  // Multiplier operand selection per operation.
  always_comb begin
    case (op)
      OP_ANGLE: begin mul_a = OPD_W'(m);     mul_b = OPD_W'(DEG_K);   end
      OP_C1S2:  begin mul_a = c1;            mul_b = s2;              end
      OP_S1C2:  begin mul_a = s1;            mul_b = c2;              end
      OP_T2CD:  begin mul_a = tmp;           mul_b = cd;              end
      OP_C2SD:  begin mul_a = c2;            mul_b = sd;              end
      OP_S1S2:  begin mul_a = s1;            mul_b = s2;              end
      OP_C1C2:  begin mul_a = c1;            mul_b = c2;              end
      OP_T4CD:  begin mul_a = tmp;           mul_b = cd;              end
      OP_AA:    begin mul_a = acc_a;         mul_b = acc_a;           end
      OP_BB:    begin mul_a = acc_b;         mul_b = acc_b;           end
      OP_DIST:  begin mul_a = zq;            mul_b = OPD_W'(EARTH_K); end
      default:  begin mul_a = '0;            mul_b = '0;              end
    endcase
  end

  // Q30 products are brought back to Q30 by a floor shift.
  assign prod_sh = OPD_W'(prod >>> 30);
  assign sq_sum  = sq + prod[63:0];

  // The scaled angle is folded into [-pi/2, pi/2]; the sine and cosine of
  // the folded angle are negated afterwards when a fold took place.
  always_comb begin
    zp    = angle_t'(prod[63:0]);
    zf    = zp;
    zflip = 1'b0;
    if (zp > HALF_A) begin
      zf    = zp - PI_A;
      zflip = 1'b1;
    end else if (zp < -HALF_A) begin
      zf    = zp + PI_A;
      zflip = 1'b1;
    end
  end

  // CORDIC commands: rotation from the gain-corrected unit vector, or
  // vectoring on (den, num), turned by -pi/2 when den is negative.
  always_comb begin
    ccmd.start     = ((state == S_MULW) && (op == OP_ANGLE)) || (state == S_VGO);
    ccmd.vectoring = (state == S_VGO);
    if (state == S_VGO) begin
      if (den >= 0) begin
        cx_init = XY_W'(den);
        cy_init = XY_W'({1'b0, num});
        cz_init = '0;
      end else begin
        cx_init = XY_W'({1'b0, num});
        cy_init = -XY_W'(den);
        cz_init = HALF_A;
      end
    end else begin
      cx_init = XY_W'({1'b0, INV_GAIN[XY_W-2:0]});
      cy_init = '0;
      cz_init = zf;
    end
  end

  assign sq_start = (state == S_MULW) && (op == OP_BB);

  always_comb begin
    cval   = flip ? -OPD_W'(cx) : OPD_W'(cx);
    sval   = flip ? -OPD_W'(cy) : OPD_W'(cy);
    zabs   = (cz < 0) ? -cz : cz;
    dround = prod[63:0] + 64'h0000_0000_8000_0000;
    dval   = dround[63:32];
  end

  // Angle for the next rotation pass, in 1e-7 degree.
  always_comb begin
    case (sel)
      SEL_LAT1: angle_src = RED_W'(prev_lat);
      SEL_LAT2: angle_src = RED_W'(lon_new) - RED_W'(prev_lon);
      default:  angle_src = RED_W'(lat_new);
    endcase
  end

  // Counter and total after this cycle's beat.
  always_comb begin
    elapsed_next      = elapsed;
    distance_sum_next = distance_sum;
    sum_add           = {1'b0, distance_sum} + (SUM_W + 1)'(step);
    if (in_fire && (item.mode == MODE_TICK) && (elapsed != '1)) begin
      elapsed_next = elapsed + 1'b1;
    end
    if (in_fire && (item.mode == MODE_FRAME)) begin
      elapsed_next      = '0;
      distance_sum_next = '0;
    end
    if (commit) begin
      distance_sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_ANGLE;
      sel          <= SEL_LAT1;
      time_limit   <= TIME_LIMIT_RESET;
      dist_limit   <= DIST_LIMIT_RESET;
      prev_lat     <= '0;
      prev_lon     <= '0;
      distance_sum <= '0;
      elapsed      <= '1;
      out_valid    <= 1'b0;
    end else begin
      elapsed      <= elapsed_next;
      distance_sum <= distance_sum_next;

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_TIME_LIMIT: time_limit <= cfg.data[TICK_W-1:0];
          REG_DIST_LIMIT: dist_limit <= cfg.data[SUM_W-1:0];
          default: ;
        endcase
      end

      if (out_write) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      if (in_fire && (item.mode == MODE_HOME)) begin
        prev_lat <= item.latitude;
        prev_lon <= item.longitude;
      end
      if (commit) begin
        prev_lat <= lat_new;
        prev_lon <= lon_new;
      end

      case (state)
        S_IDLE: begin
          if (in_fire && (item.mode == MODE_POS)) begin
            sel   <= SEL_LAT1;
            state <= S_RED;
          end
        end
        S_RED: begin
          // Done once the angle lies in (-180, 180] degrees.
          if (!(m > RED_HALF) && !(m <= -RED_HALF)) begin
            op    <= OP_ANGLE;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_MULW;
        S_MULW: begin
          case (op)
            OP_ANGLE: state <= S_ROT;
            OP_BB:    state <= S_SQRT;
            OP_DIST:  state <= S_DONE;
            default: begin
              op    <= op + 1'b1;
              state <= S_MUL;
            end
          endcase
        end
        S_ROT: begin
          if (cdone) begin
            if (sel == SEL_DLON) begin
              op    <= OP_C1S2;
              state <= S_MUL;
            end else begin
              sel   <= sel + 1'b1;
              state <= S_RED;
            end
          end
        end
        S_SQRT: if (sq_done) state <= S_VGO;
        S_VGO:  state <= S_VEC;
        S_VEC: begin
          if (cdone) begin
            op    <= OP_DIST;
            state <= S_MUL;
          end
        end
        S_DONE: if (res_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of one fix.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lat_new <= item.latitude;
      lon_new <= item.longitude;
      m       <= RED_W'(item.latitude);
    end

    if (state == S_RED) begin
      if (m > RED_HALF) begin
        m <= m - RED_FULL;
      end else if (m <= -RED_HALF) begin
        m <= m + RED_FULL;
      end
    end

    if (state == S_ROT && cdone) begin
      m <= angle_src;
      case (sel)
        SEL_LAT1: begin c1 <= cval; s1 <= sval; end
        SEL_LAT2: begin c2 <= cval; s2 <= sval; end
        default:  begin cd <= cval; sd <= sval; end
      endcase
    end

    if (state == S_MULW) begin
      case (op)
        OP_ANGLE: flip  <= zflip;
        OP_C1S2:  acc_a <= prod_sh;
        OP_S1C2:  tmp   <= prod_sh;
        OP_T2CD:  acc_a <= acc_a - prod_sh;
        OP_C2SD:  acc_b <= prod_sh;
        OP_S1S2:  den   <= prod_sh;
        OP_C1C2:  tmp   <= prod_sh;
        OP_T4CD:  den   <= den + prod_sh;
        OP_AA:    sq    <= prod[63:0];
        OP_BB:    sq    <= sq_sum;
        OP_DIST:  step  <= (dval > STEP_MAX) ? STEP_W'(STEP_MAX) : dval[STEP_W-1:0];
        default: ;
      endcase
    end

    if (state == S_SQRT && sq_done) begin
      num <= sq_root;
    end

    if (state == S_VEC && cdone) begin
      zq <= OPD_W'(zabs >> 28);
    end

    if (out_write) begin
      out_step  <= commit ? step : '0;
      out_total <= distance_sum_next;
      out_due   <= (elapsed_next >= time_limit) || (distance_sum_next >= dist_limit);
    end
  end

  // The travelled total only shrinks on a frame-sent beat.
  a_sum_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(in_fire && (item.mode == MODE_FRAME)) |=> (distance_sum >= $past(distance_sum)))
    else $error("travelled total decreased without a frame-sent beat");

  // Non-position beats produce their result in the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (item.mode != MODE_POS)) |=> out_valid)
    else $error("no result after a one-cycle beat");

  // A result step never exceeds the saturation distance.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (SUM_W'(out_step) <= STEP_MAX))
    else $error("step distance above its saturation value");

  // The square root only starts while a fix is in the multiply phase.
  a_sqrt_start: assert property (@(posedge clk) disable iff (rst)
    sq_start |=> (state == S_SQRT))
    else $error("square root started outside the sequence");

endmodule
